[src/k_way_merge_heap_assert.svh]
// Assertion macros for the merge heap.
`ifndef K_WAY_MERGE_HEAP_ASSERT_SVH
`define K_WAY_MERGE_HEAP_ASSERT_SVH

`ifndef SYNTHESIS
`define KWM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("k_way_merge_heap check failed");
`define KWM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("k_way_merge_heap reset check failed");
`else
`define KWM_ASSERT(lbl, prop)
`define KWM_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[src/kwm_pkg.sv]
`timescale 1ns / 1ps
package kwm_pkg;

  localparam int STREAM_COUNT_DEF = 16;
  localparam int ValueW = 32;
  localparam int StreamW = 4;
  localparam int CmdW = 2;

  localparam logic [CmdW-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CmdW-1:0] CMD_START  = 2'd1;
  localparam logic [CmdW-1:0] CMD_REFILL = 2'd2;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic [StreamW-1:0]       source;
  } heap_entry_t;

  typedef struct packed {
    logic pick_a;
    logic pick_b;
  } cmp_sel_t;

  function automatic logic entry_less(heap_entry_t a, heap_entry_t b);
    logic res;
    if (a.value != b.value) begin
      res = (a.value < b.value);
    end else begin
      res = (a.source < b.source);
    end
    return res;
  endfunction

endpackage

[src/kwm_ram.sv]
`timescale 1ns / 1ps
module kwm_ram #(
  parameter int Width = 36,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  output logic [Width-1:0]         rdata_a_o,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[src/kwm_cmp.sv]
`timescale 1ns / 1ps
module kwm_cmp import kwm_pkg::*; (
  input  heap_entry_t cur_i,
  input  heap_entry_t a_i,
  input  logic        a_vld_i,
  input  heap_entry_t b_i,
  input  logic        b_vld_i,
  output cmp_sel_t    sel_o
);

  heap_entry_t best;

  always_comb begin
    best = cur_i;
    sel_o = '0;
    if (a_vld_i && entry_less(a_i, cur_i)) begin
      best = a_i;
      sel_o.pick_a = 1'b1;
    end
    if (b_vld_i && entry_less(b_i, best)) begin
      sel_o.pick_a = 1'b0;
      sel_o.pick_b = 1'b1;
    end
  end

endmodule

[src/k_way_merge_heap.sv]
// Load: accepted in idle; each level reads the parent, then compares; the entry is placed last.
// Start/refill: refill item inserted first; root read, then captured; empty heap: done word.
// Sift-down after the result: each level reads both children, then compares and writes.
// One word in flight; a held result stalls the next pop. Ignored commands change no state.
// Reset clears size, phase and output valid; heap storage is not cleared.
`timescale 1ns / 1ps
`include "k_way_merge_heap_assert.svh"
module k_way_merge_heap import kwm_pkg::*; #(
  parameter int STREAM_COUNT = STREAM_COUNT_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [CmdW-1:0]          cmd_i,
  input  logic signed [ValueW-1:0] item_value_i,
  input  logic [StreamW-1:0]       stream_id_i,
  input  logic                     present_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [ValueW-1:0] out_value_o,
  output logic [StreamW-1:0]       out_stream_o,
  output logic                     has_value_o,
  output logic                     done_res_o
);

  localparam int IdxW = $clog2(STREAM_COUNT);
  localparam int SzW = $clog2(STREAM_COUNT + 1);
  localparam logic [SzW-1:0] Full = SzW'(STREAM_COUNT);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS_RD  = 3'd1;
  localparam logic [2:0] S_INS_CMP = 3'd2;
  localparam logic [2:0] S_POP_RD  = 3'd3;
  localparam logic [2:0] S_POP_CAP = 3'd4;
  localparam logic [2:0] S_DN_RD   = 3'd5;
  localparam logic [2:0] S_DN_CMP  = 3'd6;
  localparam logic [2:0] S_EMPTY   = 3'd7;

  logic [2:0]         state_q, state_d;
  logic [SzW-1:0]     size_q, size_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  heap_entry_t        cur_q, cur_d;
  logic [StreamW-1:0] pend_q, pend_d;
  logic               await_q, await_d;
  logic               pop_after_q, pop_after_d;
  logic               out_valid_q, out_valid_d;
  heap_entry_t        out_q, out_d;
  logic               out_has_q, out_has_d;
  logic               out_done_q, out_done_d;

  logic            we;
  logic [IdxW-1:0] waddr;
  heap_entry_t     wdata;
  logic [IdxW-1:0] ra_a;
  logic [IdxW-1:0] ra_b;
  heap_entry_t     rd_a;
  heap_entry_t     rd_b;

  logic [IdxW-1:0] parent_idx;
  logic [IdxW-1:0] last_idx;
  logic [SzW:0]    left_w;
  logic [SzW:0]    right_w;
  logic            left_vld;
  logic            right_vld;
  logic            slot_free;
  logic            cmp_a_vld;
  logic            cmp_b_vld;
  cmp_sel_t        sel;

  kwm_ram #(
    .Width($bits(heap_entry_t)),
    .Depth(STREAM_COUNT)
  ) u_heap (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(ra_a),
    .rdata_a_o(rd_a),
    .raddr_b_i(ra_b),
    .rdata_b_o(rd_b)
  );

  kwm_cmp u_cmp (
    .cur_i  (cur_q),
    .a_i    (rd_a),
    .a_vld_i(cmp_a_vld),
    .b_i    (rd_b),
    .b_vld_i(cmp_b_vld),
    .sel_o  (sel)
  );

  assign parent_idx = IdxW'((idx_q - IdxW'(1)) >> 1);
  assign last_idx   = IdxW'(size_q - SzW'(1));
  assign left_w     = (SzW + 1)'({idx_q, 1'b1});
  assign right_w    = left_w + (SzW + 1)'(1);
  assign left_vld   = left_w < {1'b0, size_q};
  assign right_vld  = right_w < {1'b0, size_q};
  assign slot_free  = !out_valid_q || out_ready_i;
  assign cmp_a_vld  = (state_q == S_INS_CMP) || ((state_q == S_DN_CMP) && left_vld);
  assign cmp_b_vld  = (state_q == S_DN_CMP) && right_vld;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    size_d      = size_q;
    idx_d       = idx_q;
    cur_d       = cur_q;
    pend_d      = pend_q;
    await_d     = await_q;
    pop_after_d = pop_after_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    out_has_d   = out_has_q;
    out_done_d  = out_done_q;
    we          = 1'b0;
    waddr       = idx_q;
    wdata       = cur_q;
    ra_a        = '0;
    ra_b        = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (cmd_i)
            CMD_LOAD: begin
              if (!await_q && present_i && (size_q < Full)) begin
                cur_d.value  = item_value_i;
                cur_d.source = stream_id_i;
                idx_d        = IdxW'(size_q);
                size_d       = size_q + SzW'(1);
                pop_after_d  = 1'b0;
                state_d      = S_INS_RD;
              end
            end
            CMD_START: begin
              if (!await_q) begin
                state_d = (size_q == '0) ? S_EMPTY : S_POP_RD;
              end
            end
            CMD_REFILL: begin
              if (await_q) begin
                if (present_i && (size_q < Full)) begin
                  cur_d.value  = item_value_i;
                  cur_d.source = pend_q;
                  idx_d        = IdxW'(size_q);
                  size_d       = size_q + SzW'(1);
                  pop_after_d  = 1'b1;
                  state_d      = S_INS_RD;
                end else begin
                  state_d = (size_q == '0) ? S_EMPTY : S_POP_RD;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_INS_RD: begin
        ra_a = parent_idx;
        if (idx_q == '0) begin
          we      = 1'b1;
          state_d = pop_after_q ? S_POP_RD : S_IDLE;
        end else begin
          state_d = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        ra_a = parent_idx;
        we   = 1'b1;
        if (!sel.pick_a) begin
          wdata   = rd_a;
          idx_d   = parent_idx;
          state_d = S_INS_RD;
        end else begin
          state_d = pop_after_q ? S_POP_RD : S_IDLE;
        end
      end
      S_POP_RD: begin
        ra_b    = last_idx;
        state_d = S_POP_CAP;
      end
      S_POP_CAP: begin
        ra_b = last_idx;
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d       = rd_a;
          out_has_d   = 1'b1;
          out_done_d  = 1'b0;
          pend_d      = rd_a.source;
          await_d     = 1'b1;
          size_d      = size_q - SzW'(1);
          cur_d       = rd_b;
          idx_d       = '0;
          state_d     = S_DN_RD;
        end
      end
      S_DN_RD: begin
        ra_a    = left_w[IdxW-1:0];
        ra_b    = right_w[IdxW-1:0];
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        ra_a = left_w[IdxW-1:0];
        ra_b = right_w[IdxW-1:0];
        we   = 1'b1;
        if (sel.pick_b) begin
          wdata   = rd_b;
          idx_d   = right_w[IdxW-1:0];
          state_d = S_DN_RD;
        end else if (sel.pick_a) begin
          wdata   = rd_a;
          idx_d   = left_w[IdxW-1:0];
          state_d = S_DN_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          out_has_d   = 1'b0;
          out_done_d  = 1'b1;
          await_d     = 1'b0;
          size_d      = '0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      size_q      <= '0;
      pend_q      <= '0;
      await_q     <= 1'b0;
      pop_after_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      size_q      <= size_d;
      pend_q      <= pend_d;
      await_q     <= await_d;
      pop_after_q <= pop_after_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    cur_q      <= cur_d;
    out_q      <= out_d;
    out_has_q  <= out_has_d;
    out_done_q <= out_done_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_q.value;
  assign out_stream_o = out_q.source;
  assign has_value_o  = out_has_q;
  assign done_res_o   = out_done_q;

  `KWM_ASSERT(a_size_max, size_q <= Full)
  `KWM_ASSERT(a_word_src, $rose(out_valid_q) |-> $past(state_q) == S_POP_CAP || $past(state_q) == S_EMPTY)
  `KWM_ASSERT(a_done_no_await, (out_valid_q && out_done_q) |-> !await_q)
  `KWM_ASSERT(a_has_xor_done, out_valid_q |-> (out_has_q ^ out_done_q))
  `KWM_ASSERT_ALWAYS(a_rst_idle, $rose(rst_ni) |-> (state_q == S_IDLE) && !out_valid_q)

endmodule

[tb/k_way_merge_heap_checker.sv]
`timescale 1ns / 1ps
module k_way_merge_heap_checker import kwm_pkg::*; #(
  parameter int STREAM_COUNT = STREAM_COUNT_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [CmdW-1:0]          cmd_i,
  input  logic signed [ValueW-1:0] item_value_i,
  input  logic [StreamW-1:0]       stream_id_i,
  input  logic                     present_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic signed [ValueW-1:0] out_value_i,
  input  logic [StreamW-1:0]       out_stream_i,
  input  logic                     has_value_i,
  input  logic                     done_res_i,
  output int unsigned              fail_count_o,
  output int unsigned              backlog_o
);

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic [StreamW-1:0]       stream;
    logic                     has_value;
    logic                     done;
  } merged_word_t;

  logic signed [ValueW-1:0] heap_val [STREAM_COUNT];
  logic [StreamW-1:0]       heap_src [STREAM_COUNT];
  int unsigned              heap_fill;
  logic [StreamW-1:0]       wanted_stream;
  logic                     awaiting_refill;
  merged_word_t             merged_q [$];
  int unsigned              mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic logic ranks_first(input int unsigned a, input int unsigned b);
    if (heap_val[a] != heap_val[b]) begin
      return heap_val[a] < heap_val[b];
    end
    return heap_src[a] < heap_src[b];
  endfunction

  task automatic swap_entries(input int unsigned a, input int unsigned b);
    logic signed [ValueW-1:0] v;
    logic [StreamW-1:0]       s;
    v = heap_val[a];
    heap_val[a] = heap_val[b];
    heap_val[b] = v;
    s = heap_src[a];
    heap_src[a] = heap_src[b];
    heap_src[b] = s;
  endtask

  task automatic sift_in(input logic signed [ValueW-1:0] value, input logic [StreamW-1:0] src);
    int unsigned i;
    int unsigned parent;
    if (heap_fill >= STREAM_COUNT) begin
      return;
    end
    i = heap_fill;
    heap_val[i] = value;
    heap_src[i] = src;
    heap_fill++;
    while (i > 0) begin
      parent = (i - 1) / 2;
      if (!ranks_first(i, parent)) begin
        break;
      end
      swap_entries(i, parent);
      i = parent;
    end
  endtask

  task automatic pop_min();
    merged_word_t w;
    int unsigned  i;
    int unsigned  left;
    int unsigned  right;
    int unsigned  best;
    if (heap_fill == 0) begin
      w.value = '0;
      w.stream = '0;
      w.has_value = 1'b0;
      w.done = 1'b1;
      awaiting_refill = 1'b0;
    end else begin
      w.value = heap_val[0];
      w.stream = heap_src[0];
      w.has_value = 1'b1;
      w.done = 1'b0;
      wanted_stream = heap_src[0];
      awaiting_refill = 1'b1;
      heap_fill--;
      heap_val[0] = heap_val[heap_fill];
      heap_src[0] = heap_src[heap_fill];
      i = 0;
      forever begin
        left = 2 * i + 1;
        right = left + 1;
        best = i;
        if (left < heap_fill && ranks_first(left, best)) begin
          best = left;
        end
        if (right < heap_fill && ranks_first(right, best)) begin
          best = right;
        end
        if (best == i) begin
          break;
        end
        swap_entries(i, best);
        i = best;
      end
    end
    merged_q = {merged_q, w};
  endtask

  task automatic check_field(input string name, input logic signed [ValueW-1:0] want,
                             input logic signed [ValueW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    merged_word_t want;
    if (!rst_ni) begin
      heap_fill = 0;
      wanted_stream = '0;
      awaiting_refill = 1'b0;
      merged_q.delete();
      backlog_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (merged_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, got %0d %0d %0b %0b", $time,
                   out_value_i, out_stream_i, has_value_i, done_res_i);
          mismatches++;
        end else begin
          want = merged_q.pop_front();
          check_field("out_value", want.value, out_value_i);
          check_field("out_stream", ValueW'(want.stream), ValueW'(out_stream_i));
          check_field("has_value", ValueW'(want.has_value), ValueW'(has_value_i));
          check_field("done_res", ValueW'(want.done), ValueW'(done_res_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        case (cmd_i)
          CMD_LOAD: begin
            if (!awaiting_refill && present_i) begin
              sift_in(item_value_i, stream_id_i);
            end
          end
          CMD_START: begin
            if (!awaiting_refill) begin
              pop_min();
            end
          end
          CMD_REFILL: begin
            if (awaiting_refill) begin
              if (present_i) begin
                sift_in(item_value_i, wanted_stream);
              end
              pop_min();
            end
          end
          default: begin
          end
        endcase
      end
      backlog_o <= merged_q.size();
    end
  end

endmodule

[tb/tb_k_way_merge_heap.sv]
`timescale 1ns / 1ps
module tb_k_way_merge_heap;
  import kwm_pkg::*;

  localparam int unsigned STREAMS = STREAM_COUNT_DEF;
  localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned WORDS_PER_PHASE = 205;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 40;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [CmdW-1:0]          cmd_i = CMD_LOAD;
  logic signed [ValueW-1:0] item_value_i = '0;
  logic [StreamW-1:0]       stream_id_i = '0;
  logic                     present_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [ValueW-1:0] out_value_o;
  logic [StreamW-1:0]       out_stream_o;
  logic                     has_value_o;
  logic                     done_res_o;

  int unsigned fail_count;
  int unsigned backlog;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;
  int unsigned useful_words = 0;
  int unsigned live_size = 0;
  bit          merging = 1'b0;

  k_way_merge_heap #(
    .STREAM_COUNT(STREAMS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .item_value_i(item_value_i),
    .stream_id_i (stream_id_i),
    .present_i   (present_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_value_o (out_value_o),
    .out_stream_o(out_stream_o),
    .has_value_o (has_value_o),
    .done_res_o  (done_res_o)
  );

  k_way_merge_heap_checker #(
    .STREAM_COUNT(STREAMS)
  ) merge_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .cmd_i       (cmd_i),
    .item_value_i(item_value_i),
    .stream_id_i (stream_id_i),
    .present_i   (present_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_value_i (out_value_o),
    .out_stream_i(out_stream_o),
    .has_value_i (has_value_o),
    .done_res_i  (done_res_o),
    .fail_count_o(fail_count),
    .backlog_o   (backlog)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("k_way_merge_heap regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [ValueW-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2, 3, 4: return $urandom;
      default: return $urandom_range(64) - 32;
    endcase
  endfunction

  task automatic send_word(input logic [CmdW-1:0] cmd, input logic signed [ValueW-1:0] value,
                           input logic [StreamW-1:0] sid, input logic present);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    item_value_i <= value;
    stream_id_i <= sid;
    present_i <= present;
    do @(posedge clk_i); while (!in_ready_o);
    case (cmd)
      CMD_LOAD: begin
        if (!merging && present && live_size < STREAMS) begin
          live_size++;
          useful_words++;
        end
      end
      CMD_START: begin
        if (!merging) begin
          useful_words++;
          if (live_size != 0) begin
            live_size--;
            merging = 1'b1;
          end
        end
      end
      CMD_REFILL: begin
        if (merging) begin
          useful_words++;
          if (present) begin
            live_size++;
          end
          if (live_size == 0) begin
            merging = 1'b0;
          end else begin
            live_size--;
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  // hold the sender until every merged word is back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (backlog != 0);
  endtask

  task automatic run_phase(input int unsigned target);
    int unsigned goal;
    int unsigned loads;
    int unsigned refills;
    goal = useful_words + target;
    refills = 0;
    while (useful_words < goal) begin
      if (!merging) begin
        case ($urandom_range(9))
          0: loads = $urandom_range(20, 17);
          1, 2: loads = $urandom_range(16, 9);
          default: loads = $urandom_range(8, 0);
        endcase
        for (int n = 0; n < loads; n++) begin
          if ($urandom_range(11) == 0) begin
            send_word(CmdW'($urandom_range(3)), pick_value(), StreamW'($urandom_range(15)),
                      $urandom_range(1) == 1);
          end
          send_word(CMD_LOAD, pick_value(), StreamW'($urandom_range(15)),
                    $urandom_range(9) != 0);
        end
        send_word(CMD_START, pick_value(), StreamW'($urandom_range(15)),
                  $urandom_range(1) == 1);
        refills = 0;
      end else if ($urandom_range(9) == 0) begin
        send_word(CmdW'($urandom_range(3)), pick_value(), StreamW'($urandom_range(15)),
                  $urandom_range(1) == 1);
      end else begin
        send_word(CMD_REFILL, pick_value(), StreamW'($urandom_range(15)),
                  (refills < 24) && ($urandom_range(1) == 1));
        refills++;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_word(CMD_START, '0, '0, 1'b0);
    send_word(CMD_REFILL, 32'sd5, 4'd1, 1'b1);
    send_word(CMD_UNUSED, -32'sd1, 4'd15, 1'b1);
    send_word(CMD_LOAD, 32'sd9, 4'd7, 1'b0);
    send_word(CMD_LOAD, 32'h7fff_ffff, 4'd15, 1'b1);
    send_word(CMD_LOAD, 32'h8000_0000, 4'd0, 1'b1);
    send_word(CMD_LOAD, -32'sd1, 4'd5, 1'b1);
    send_word(CMD_LOAD, 32'sd0, 4'd3, 1'b1);
    send_word(CMD_LOAD, 32'sd0, 4'd3, 1'b1);
    send_word(CMD_LOAD, 32'sd0, 4'd2, 1'b1);
    send_word(CMD_START, '0, '0, 1'b0);
    send_word(CMD_LOAD, -32'sd5, 4'd1, 1'b1);
    send_word(CMD_START, '0, '0, 1'b1);
    send_word(CMD_REFILL, 32'sd100, 4'd9, 1'b1);
    for (int k = 0; k < 6; k++) begin
      send_word(CMD_REFILL, 32'sd77, 4'd4, 1'b0);
    end
    drain();

    run_phase(WORDS_PER_PHASE);
    drain();
    idle_pct = 66;
    run_phase(WORDS_PER_PHASE);
    drain();
    idle_pct = 0;
    stall_pct = 66;
    run_phase(WORDS_PER_PHASE);
    drain();
    idle_pct = 21;
    stall_pct = 21;
    run_phase(WORDS_PER_PHASE);
    drain();

    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("k_way_merge_heap regression: pass");
    end else begin
      $display("k_way_merge_heap regression: fail");
    end
    $finish;
  end

endmodule
